/* rtl/svv_pkg.sv */
package svv_pkg;

  // Longest accepted version string in bytes
  localparam int MAX_LEN = 64;
  // Byte counter width, wide enough to hold MAX_LEN itself
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // Character codes of the grammar
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Part of the version string being parsed
  typedef enum logic [2:0] {
    SEC_MAJOR = 3'd0,
    SEC_MINOR = 3'd1,
    SEC_PATCH = 3'd2,
    SEC_PRE   = 3'd3,
    SEC_BUILD = 3'd4
  } section_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    section_t         section;
    logic [1:0]       tok_len;
    logic             starts_zero;
    logic             all_digits;
    logic             failed;
    logic [CNT_W-1:0] byte_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    section:     SEC_MAJOR,
    tok_len:     2'd0,
    starts_zero: 1'b0,
    all_digits:  1'b1,
    failed:      1'b0,
    byte_count:  '0
  };

endpackage

/* rtl/svv_step.sv */
module svv_step (
  input  svv_pkg::state_t cur,
  input  logic [7:0]      char_byte,
  input  logic            last_byte,
  output svv_pkg::state_t nxt,
  output logic            result
);

  logic               digit;
  logic               ident;
  logic               add;
  logic               close;
  svv_pkg::section_t  close_sec;
  svv_pkg::state_t    upd;

  // True if the current identifier may end here under the section's rules
  function automatic logic tok_ok(svv_pkg::section_t sec, logic [1:0] len,
                                  logic sz, logic ad);
    logic lead_zero;
    logic ok;
    lead_zero = (len == 2'd2) && sz;
    unique case (sec)
      svv_pkg::SEC_MAJOR, svv_pkg::SEC_MINOR, svv_pkg::SEC_PATCH: ok = !lead_zero;
      svv_pkg::SEC_PRE:   ok = !(lead_zero && ad);
      svv_pkg::SEC_BUILD: ok = 1'b1;
      default:            ok = 1'b0;
    endcase
    return ok && (len != 2'd0);
  endfunction

  // Classify the byte
  assign digit = (char_byte >= svv_pkg::CH_ZERO) && (char_byte <= svv_pkg::CH_NINE);
  assign ident = digit || (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
                 (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                 (char_byte == svv_pkg::CH_MINUS);

  always_comb begin
    upd       = cur;
    add       = 1'b0;
    close     = 1'b0;
    close_sec = cur.section;

    // Count bytes, fail past the length limit
    if (cur.byte_count >= svv_pkg::CNT_W'(svv_pkg::MAX_LEN)) begin
      upd.failed = 1'b1;
    end else begin
      upd.byte_count = cur.byte_count + svv_pkg::CNT_W'(1);
    end

    // Decide what the byte does in this section
    unique case (cur.section)
      svv_pkg::SEC_MAJOR, svv_pkg::SEC_MINOR, svv_pkg::SEC_PATCH: begin
        if (digit) begin
          add = 1'b1;
        end else if (char_byte == svv_pkg::CH_DOT && cur.section != svv_pkg::SEC_PATCH) begin
          close     = 1'b1;
          close_sec = (cur.section == svv_pkg::SEC_MAJOR) ? svv_pkg::SEC_MINOR
                                                          : svv_pkg::SEC_PATCH;
        end else if (char_byte == svv_pkg::CH_MINUS && cur.section == svv_pkg::SEC_PATCH) begin
          close     = 1'b1;
          close_sec = svv_pkg::SEC_PRE;
        end else if (char_byte == svv_pkg::CH_PLUS && cur.section == svv_pkg::SEC_PATCH) begin
          close     = 1'b1;
          close_sec = svv_pkg::SEC_BUILD;
        end else begin
          upd.failed = 1'b1;
        end
      end
      svv_pkg::SEC_PRE: begin
        if (ident) begin
          add = 1'b1;
        end else if (char_byte == svv_pkg::CH_DOT) begin
          close = 1'b1;
        end else if (char_byte == svv_pkg::CH_PLUS) begin
          close     = 1'b1;
          close_sec = svv_pkg::SEC_BUILD;
        end else begin
          upd.failed = 1'b1;
        end
      end
      svv_pkg::SEC_BUILD: begin
        if (ident) begin
          add = 1'b1;
        end else if (char_byte == svv_pkg::CH_DOT) begin
          close = 1'b1;
        end else begin
          upd.failed = 1'b1;
        end
      end
      default: upd.failed = 1'b1;
    endcase

    // Extend the identifier
    if (add) begin
      if (cur.tok_len == 2'd0) begin
        upd.starts_zero = (char_byte == svv_pkg::CH_ZERO);
      end
      if (!digit) begin
        upd.all_digits = 1'b0;
      end
      if (cur.tok_len != 2'd2) begin
        upd.tok_len = cur.tok_len + 2'd1;
      end
    end

    // End the identifier and move on
    if (close) begin
      if (!tok_ok(cur.section, cur.tok_len, cur.starts_zero, cur.all_digits)) begin
        upd.failed = 1'b1;
      end
      upd.section     = close_sec;
      upd.tok_len     = 2'd0;
      upd.starts_zero = 1'b0;
      upd.all_digits  = 1'b1;
    end

    // Judge the whole string on its final byte
    result = !upd.failed &&
             (upd.section == svv_pkg::SEC_PATCH || upd.section == svv_pkg::SEC_PRE ||
              upd.section == svv_pkg::SEC_BUILD) &&
             tok_ok(upd.section, upd.tok_len, upd.starts_zero, upd.all_digits);

    nxt = last_byte ? svv_pkg::STATE_RESET : upd;
  end

endmodule

/* rtl/semver_string_validator_unit.sv */
// Semantic version string checker.
// Input channel s_*: one byte of the version string per request, s_tlast
// on the final byte. Output channel m_*: one request per string, carrying
// is_valid, issued after the final byte only; other bytes give nothing.
// A byte is first held in the input register, then its state update and any
// result are registered, so is_valid comes from the output register.
// Throughput: one byte per cycle, but a final byte waits while a result is
// untaken. The parse state is a handful of flags, a section code and a
// byte counter, computed combinationally by svv_step.
// Strings longer than MAX_LEN bytes are reported invalid.
// Reset (rst, synchronous) empties both registers and returns the parser
// to the start of a string.
// When the receiver stalls, the result waits in the output register; the
// block still takes bytes that are not final, and a final byte waits in
// the input register until the result ahead of it is taken.
module semver_string_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] is_valid, [7:1] zero
);

  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_last;
  logic            in_fire;
  logic            out_free;
  logic            is_valid;
  logic            result;
  svv_pkg::state_t st;
  svv_pkg::state_t st_next;

  svv_step u_step (
    .cur       (st),
    .char_byte (in_byte),
    .last_byte (in_last),
    .nxt       (st_next),
    .result    (result)
  );

  // Advance a byte unless it is final and the result slot is busy
  assign out_free = !m_tvalid || m_tready;
  assign in_fire  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || in_fire;

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Update parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= svv_pkg::STATE_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire && in_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (in_fire && in_last) begin
      is_valid <= result;
    end
  end

  assign m_tdata = {7'd0, is_valid};

  // A final byte leaves the parser at the start of a string
  assert property (@(posedge clk) disable iff (rst)
    in_fire && in_last |=> st.section == svv_pkg::SEC_MAJOR && st.byte_count == '0)
    else $error("parser not restarted after final byte");

  // Byte counter never passes the limit
  assert property (@(posedge clk) disable iff (rst)
    st.byte_count <= svv_pkg::CNT_W'(svv_pkg::MAX_LEN))
    else $error("byte counter beyond limit");

  // A result appears only after a final byte advanced
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_fire && in_last))
    else $error("result without final byte");

  // A pending final byte never overwrites an untaken result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(in_fire && in_last))
    else $error("result overwritten while stalled");

  // Input is refused only while a final byte is held and the result slot is busy
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && in_last && !out_free)
    else $error("input stalled without cause");

endmodule
